FILE: hw/rtl/iss_pkg.sv
package iss_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 8;

  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 8;
  localparam int COUNT_W = 5;

  // Wide enough to hold any position or count up to the largest capacity.
  localparam int CELL_POS_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [CELL_POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/iss_if.sv
interface iss_req_if;
  logic                        valid;
  logic                        ready;
  logic [iss_pkg::OP_W-1:0]    op;
  logic [iss_pkg::POS_W-1:0]   position;
  logic [iss_pkg::VALUE_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
  modport mon    (input valid, ready, op, position, value);
endinterface

interface iss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iss_pkg::VALUE_W-1:0] read_value;
  logic                        succeeded;
  logic                        is_empty;
  logic [iss_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, read_value, succeeded, is_empty, entry_count, input ready);
  modport sink   (input valid, read_value, succeeded, is_empty, entry_count, output ready);
  modport mon    (input valid, ready, read_value, succeeded, is_empty, entry_count);
endinterface

FILE: hw/rtl/indexed_sequence_store_top.sv
// A request is answered from an output register in the cycle after it is accepted.
// Throughput: one request per cycle unless the response is stalled; all cells that shift do so together.
// A new request is taken whenever the output register is empty or is being drained.
// Reset (rst, synchronous) clears the count and the output valid; the cells are not cleared.
module indexed_sequence_store_top #(
  parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  iss_req_if.sink   req,
  iss_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > iss_pkg::POS_W) ? CNT_W : iss_pkg::POS_W;
  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW    = (DATA_WIDTH > iss_pkg::VALUE_W) ? DATA_WIDTH : iss_pkg::VALUE_W;
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);
  localparam logic [XW-1:0] ONES_X = XW'({DATA_WIDTH{1'b1}});

  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [CW-1:0]          cnt_x;
  logic [CW-1:0]          pos_x;
  logic [XW-1:0]          val_x;
  logic [XW-1:0]          rd_x;
  logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
  logic                   accept;
  logic                   full;
  logic                   ok;
  logic                   ins_ok;
  logic                   rem_ok;
  iss_pkg::cell_cmd_t     cmd;
  iss_pkg::op_t           op;

  assign accept  = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign op      = iss_pkg::op_t'(req.op);
  assign cnt_x   = CW'(cnt);
  assign pos_x   = CW'(req.position);
  assign val_x   = XW'(req.value);
  assign full    = (cnt_x == CAP_V);

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    ok     = 1'b0;
    unique case (op)
      iss_pkg::OP_APPEND: ins_ok = !full;
      iss_pkg::OP_INSERT: ins_ok = !full && (pos_x <= cnt_x);
      iss_pkg::OP_READ:   ok     = (pos_x < cnt_x);
      iss_pkg::OP_REMOVE: rem_ok = (pos_x < cnt_x);
      default:            ok     = 1'b0;
    endcase
    ok = ok || ins_ok || rem_ok;
  end

  always_comb begin
    cmd.ins = accept && ins_ok;
    cmd.rem = accept && rem_ok;
    cmd.pos = (op == iss_pkg::OP_APPEND) ? iss_pkg::CELL_POS_W'(cnt_x)
                                         : iss_pkg::CELL_POS_W'(pos_x);
    cnt_next = cnt;
    if (cmd.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.rem) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_comb begin
    rd_x = ONES_X;
    if (op == iss_pkg::OP_READ && ok) begin
      rd_x = XW'(cell_data[pos_x[IW-1:0]]);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = val_x[DATA_WIDTH-1:0];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    iss_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_data   (val_x[DATA_WIDTH-1:0]),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.read_value  <= rd_x[iss_pkg::VALUE_W-1:0];
      rsp.succeeded   <= ok;
      rsp.is_empty    <= (cnt_next == '0);
      rsp.entry_count <= iss_pkg::COUNT_W'(cnt_next);
    end
  end

endmodule

FILE: hw/rtl/iss_cell.sv
module iss_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  iss_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [iss_pkg::CELL_POS_W-1:0] IDX_V = iss_pkg::CELL_POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (IDX_V > cmd.pos) begin
        data_next = left_data;
      end else if (IDX_V == cmd.pos) begin
        data_next = new_data;
      end
    end else if (cmd.rem) begin
      if (IDX_V >= cmd.pos) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: hw/rtl/iss_checker.sv
module iss_checker #(
  parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [iss_pkg::VALUE_W-1:0] rsp_read_value,
  input logic                        rsp_succeeded,
  input logic                        rsp_is_empty,
  input logic [iss_pkg::COUNT_W-1:0] rsp_entry_count
);

  localparam int XW = (DATA_WIDTH > iss_pkg::VALUE_W) ? DATA_WIDTH : iss_pkg::VALUE_W;
  localparam logic [XW-1:0] ONES_X = XW'({DATA_WIDTH{1'b1}});
  localparam logic [iss_pkg::VALUE_W-1:0] FAIL_RD = ONES_X[iss_pkg::VALUE_W-1:0];
  localparam logic [iss_pkg::COUNT_W-1:0] CAP_C = iss_pkg::COUNT_W'(CAPACITY);

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_failed_reads_ones: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_succeeded) |-> (rsp_read_value == FAIL_RD))
    else $error("failed request returned data other than all ones");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst || CAPACITY > 31)
    rsp_valid |-> (rsp_entry_count <= CAP_C))
    else $error("entry_count exceeds capacity");

  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request taken while response stalled");

  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request produced no response");

endmodule

bind indexed_sequence_store_top iss_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_iss_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_value  (rsp.read_value),
  .rsp_succeeded   (rsp.succeeded),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_entry_count (rsp.entry_count)
);

FILE: tb/indexed_sequence_store_top_test.sv
`timescale 1ns / 100ps

module indexed_sequence_store_top_test;

  localparam int STORE_DEPTH    = iss_pkg::CAPACITY_DEF;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    iss_pkg::op_t                op;
    logic [iss_pkg::POS_W-1:0]   position;
    logic [iss_pkg::VALUE_W-1:0] value;
  } store_request_t;

  typedef struct packed {
    logic [iss_pkg::VALUE_W-1:0] read_value;
    logic                        succeeded;
    logic                        is_empty;
    logic [iss_pkg::COUNT_W-1:0] entry_count;
  } store_result_t;

  logic clk;
  logic rst;

  iss_req_if req_ch ();
  iss_rsp_if rsp_ch ();

  indexed_sequence_store_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  store_request_t pend_q[$];
  store_result_t  exp_q[$];
  store_request_t next_req;
  store_result_t  want;

  logic [iss_pkg::VALUE_W-1:0] seq_bytes [STORE_DEPTH];
  int                          seq_len;

  int gen_len;
  bit gen_filling;

  int send_idle_pct;
  int rsp_stall_pct;
  bit hold_req;
  bit hold_done;
  int hold_count;
  int idle_cycles;
  int err_count;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, int got, int expected);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, expected, $realtime);
    err_count++;
  endtask

  function automatic store_result_t apply_request(iss_pkg::op_t op,
                                                  logic [iss_pkg::POS_W-1:0] pos,
                                                  logic [iss_pkg::VALUE_W-1:0] val);
    store_result_t res;
    int p;
    p = int'(pos);
    res.read_value = '1;
    res.succeeded  = 1'b0;
    case (op) inside
      iss_pkg::OP_APPEND, iss_pkg::OP_INSERT: begin
        if (op == iss_pkg::OP_APPEND) p = seq_len;
        if (seq_len < STORE_DEPTH && p <= seq_len) begin
          for (int i = seq_len; i > p; i--) seq_bytes[i] = seq_bytes[i-1];
          seq_bytes[p] = val;
          seq_len++;
          res.succeeded = 1'b1;
        end
      end
      iss_pkg::OP_READ: begin
        if (p < seq_len) begin
          res.read_value = seq_bytes[p];
          res.succeeded  = 1'b1;
        end
      end
      default: begin
        if (p < seq_len) begin
          for (int i = p; i + 1 < seq_len; i++) seq_bytes[i] = seq_bytes[i+1];
          seq_len--;
          res.succeeded = 1'b1;
        end
      end
    endcase
    res.is_empty    = (seq_len == 0);
    res.entry_count = iss_pkg::COUNT_W'(seq_len);
    return res;
  endfunction

  // The generator keeps its own count so that positions can be aimed at the live range.
  task automatic push_req(iss_pkg::op_t op, int pos, int val);
    store_request_t r;
    r.op       = op;
    r.position = iss_pkg::POS_W'(pos);
    r.value    = iss_pkg::VALUE_W'(val);
    case (op)
      iss_pkg::OP_APPEND: if (gen_len < STORE_DEPTH) gen_len++;
      iss_pkg::OP_INSERT: if (gen_len < STORE_DEPTH && pos <= gen_len) gen_len++;
      iss_pkg::OP_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
    pend_q.insert(pend_q.size(), r);
  endtask

  task automatic push_random_req();
    int r;
    int pos;
    iss_pkg::op_t op;
    r = $urandom_range(0, 99);
    if (gen_len == STORE_DEPTH) gen_filling = 1'b0;
    else if (gen_len == 0) gen_filling = 1'b1;
    else if ($urandom_range(0, 99) < 3) gen_filling = ~gen_filling;
    if (r < 7) begin
      op  = iss_pkg::op_t'($urandom_range(0, 3));
      pos = $urandom_range(0, 31);
    end else if (r < 14) begin
      op  = iss_pkg::op_t'($urandom_range(1, 3));
      pos = (op == iss_pkg::OP_INSERT) ? gen_len + 1 : gen_len;
    end else begin
      r = $urandom_range(0, 99);
      if (gen_filling) begin
        if (r < 45) op = iss_pkg::OP_APPEND;
        else if (r < 75) op = iss_pkg::OP_INSERT;
        else if (r < 90) op = iss_pkg::OP_READ;
        else op = iss_pkg::OP_REMOVE;
      end else begin
        if (r < 10) op = iss_pkg::OP_APPEND;
        else if (r < 20) op = iss_pkg::OP_INSERT;
        else if (r < 45) op = iss_pkg::OP_READ;
        else op = iss_pkg::OP_REMOVE;
      end
      case (op)
        iss_pkg::OP_APPEND: pos = $urandom_range(0, 31);
        iss_pkg::OP_INSERT: pos = $urandom_range(0, gen_len);
        default: pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : $urandom_range(0, 31);
      endcase
    end
    push_req(op, pos, $urandom_range(0, 255));
  endtask

  task automatic drain_all();
    while (pend_q.size() != 0 || req_ch.valid || exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int n_items, int idle_pct, int stall_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (n_items) push_random_req();
    drain_all();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pend_q.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.op       <= next_req.op;
        req_ch.position <= next_req.position;
        req_ch.value    <= next_req.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      rsp_ch.ready <= 1'b0;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (exp_q.size() == 0) begin
          report_mismatch("unexpected result, entry_count", rsp_ch.entry_count, 0);
        end else begin
          want = exp_q.pop_front();
          if (rsp_ch.read_value !== want.read_value)
            report_mismatch("read_value", rsp_ch.read_value, want.read_value);
          if (rsp_ch.succeeded !== want.succeeded)
            report_mismatch("succeeded", rsp_ch.succeeded, want.succeeded);
          if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", rsp_ch.is_empty, want.is_empty);
          if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
        end
      end
      if (req_ch.valid && req_ch.ready)
        exp_q.insert(exp_q.size(),
                     apply_request(iss_pkg::op_t'(req_ch.op), req_ch.position, req_ch.value));
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL indexed_sequence_store_top");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.op       = iss_pkg::OP_APPEND;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    seq_len         = 0;
    gen_len         = 0;
    gen_filling     = 1'b1;
    send_idle_pct   = 0;
    rsp_stall_pct   = 0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    hold_count      = 0;
    err_count       = 0;
    for (int i = 0; i < STORE_DEPTH; i++) seq_bytes[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    push_req(iss_pkg::OP_READ, 0, 8'h3C);
    push_req(iss_pkg::OP_REMOVE, 0, 8'hC3);
    push_req(iss_pkg::OP_INSERT, 1, 8'h11);
    push_req(iss_pkg::OP_INSERT, 0, 8'h00);
    push_req(iss_pkg::OP_APPEND, 31, 8'hFF);
    push_req(iss_pkg::OP_INSERT, 2, 8'h5A);
    push_req(iss_pkg::OP_INSERT, 1, 8'hA5);
    push_req(iss_pkg::OP_READ, 31, 8'h00);
    push_req(iss_pkg::OP_REMOVE, 31, 8'hFF);
    for (int i = 0; i < 12; i++) push_req(iss_pkg::OP_APPEND, (i * 7) % 32, (i * 37 + 1) % 256);
    push_req(iss_pkg::OP_APPEND, 0, 8'h77);
    push_req(iss_pkg::OP_INSERT, 0, 8'h88);
    push_req(iss_pkg::OP_READ, 16, 8'h00);
    push_req(iss_pkg::OP_READ, 15, 8'hFF);
    push_req(iss_pkg::OP_REMOVE, 15, 8'h00);
    push_req(iss_pkg::OP_REMOVE, 0, 8'h00);
    push_req(iss_pkg::OP_READ, 0, 8'h00);
    drain_all();

    run_random(400, 0, 0);
    run_random(400, 67, 0);

    // The response side holds off while requests keep coming, so the store stalls its input.
    @(negedge clk);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (40) push_random_req();
    hold_req = 1'b1;
    while (!hold_done) @(negedge clk);
    drain_all();

    run_random(400, 0, 67);
    run_random(400, 20, 20);
    run_random(100, 0, 0);

    repeat (5) @(posedge clk);
    if (exp_q.size() != 0) report_mismatch("results still expected", 0, exp_q.size());
    if (err_count == 0) begin
      $display("PASS indexed_sequence_store_top");
    end else begin
      $display("FAIL indexed_sequence_store_top");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/iss_pkg.sv
hw/rtl/iss_if.sv
hw/rtl/iss_cell.sv
hw/rtl/indexed_sequence_store_top.sv
hw/rtl/iss_checker.sv
tb/indexed_sequence_store_top_test.sv
